@@ src/mtep_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the midi track event parser
// no dependencies
package mtep_pkg;

  localparam int MTEP_TICK_BITS  = 32;
  localparam int MTEP_COUNT_BITS = 32;

  localparam logic [23:0] TEMPO_RESET = 24'd500000;

  // event classes on the result channel
  localparam logic [3:0] CLS_NOTE_ON  = 4'd0;
  localparam logic [3:0] CLS_NOTE_OFF = 4'd1;
  localparam logic [3:0] CLS_CHAN     = 4'd2;
  localparam logic [3:0] CLS_SYSEX    = 4'd3;
  localparam logic [3:0] CLS_SYSTEM   = 4'd4;
  localparam logic [3:0] CLS_TEMPO    = 4'd5;
  localparam logic [3:0] CLS_END      = 4'd6;
  localparam logic [3:0] CLS_META     = 4'd7;
  localparam logic [3:0] CLS_ERROR    = 4'd8;

  typedef struct packed {
    logic        event_end;
    logic [3:0]  event_class;
    logic [3:0]  channel;
    logic [31:0] tick_time;
    logic [31:0] note_total;
    logic [15:0] voices;
    logic [23:0] tempo_us;
    logic        track_done;
  } mtep_result_t;

endpackage

@@ src/mtep_parse.sv @@
`timescale 1ns / 1ps
// parser state and single-pass byte decode for the midi track event parser
// depends on mtep_pkg
module mtep_parse import mtep_pkg::*; #(
  parameter int TICK_BITS  = MTEP_TICK_BITS,
  parameter int COUNT_BITS = MTEP_COUNT_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         track_start,
  output mtep_result_t res
);

  localparam logic [3:0] PH_DELTA  = 4'd0;
  localparam logic [3:0] PH_STATUS = 4'd1;
  localparam logic [3:0] PH_CHAN   = 4'd2;
  localparam logic [3:0] PH_SYSEX  = 4'd3;
  localparam logic [3:0] PH_SYS    = 4'd4;
  localparam logic [3:0] PH_MTYPE  = 4'd5;
  localparam logic [3:0] PH_MLEN   = 4'd6;
  localparam logic [3:0] PH_MDATA  = 4'd7;
  localparam logic [3:0] PH_DONE   = 4'd8;

  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_PRESS    = 4'hD;

  localparam int SW = ((TICK_BITS > 28) ? TICK_BITS : 28) + 1;

  logic [3:0]            phase_r, phase_nxt;
  logic [7:0]            running_r, running_nxt;
  logic [7:0]            cur_r, cur_nxt;
  logic [7:0]            meta_r, meta_nxt;
  logic [27:0]           vlq_r, vlq_nxt;
  logic [27:0]           skip_r, skip_nxt;
  logic [1:0]            dl_r, dl_nxt;
  logic [TICK_BITS-1:0]  tick_r, tick_nxt;
  logic [COUNT_BITS-1:0] note_r, note_nxt;
  logic [15:0]           poly_r, poly_nxt;
  logic [23:0]           tempo_r, tempo_nxt;
  logic                  ended_r, ended_nxt;

  logic       ev_end;
  logic [3:0] ev_cls;
  logic [3:0] ev_ch;

  always_comb begin
    logic [27:0]   vlq_sh7;
    logic [SW-1:0] tsum;
    logic          do_fin;
    logic          do_chan;
    logic          do_meta;
    logic          meta_load;
    logic          to_done;
    logic [3:0]    fin_cls;

    phase_nxt   = phase_r;
    running_nxt = running_r;
    cur_nxt     = cur_r;
    meta_nxt    = meta_r;
    vlq_nxt     = vlq_r;
    skip_nxt    = skip_r;
    dl_nxt      = dl_r;
    tick_nxt    = tick_r;
    note_nxt    = note_r;
    poly_nxt    = poly_r;
    tempo_nxt   = tempo_r;
    ended_nxt   = ended_r;
    do_fin      = 1'b0;
    do_chan     = 1'b0;
    do_meta     = 1'b0;
    meta_load   = 1'b0;
    to_done     = 1'b0;
    fin_cls     = CLS_NOTE_ON;
    ev_end      = 1'b0;
    ev_cls      = CLS_NOTE_ON;
    ev_ch       = 4'd0;

    // a new track restarts the parse before this byte is looked at
    if (track_start) begin
      tick_nxt    = '0;
      running_nxt = 8'd0;
      ended_nxt   = 1'b0;
      vlq_nxt     = 28'd0;
      skip_nxt    = 28'd0;
      dl_nxt      = 2'd0;
      phase_nxt   = PH_DELTA;
    end

    vlq_sh7 = {vlq_nxt[20:0], data_byte[6:0]};
    tsum    = SW'(tick_nxt) + SW'(vlq_sh7);

    case (phase_nxt)
      PH_DELTA: begin
        vlq_nxt = vlq_sh7;
        if (!data_byte[7]) begin
          if (|tsum[SW-1:TICK_BITS]) tick_nxt = '1;
          else tick_nxt = tsum[TICK_BITS-1:0];
          vlq_nxt   = 28'd0;
          phase_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (data_byte[7]) begin
          cur_nxt = data_byte;
          if (data_byte < ST_SYSEX) begin
            running_nxt = data_byte;
            dl_nxt = (data_byte[7:4] == HI_PROG || data_byte[7:4] == HI_PRESS) ? 2'd1 : 2'd2;
            phase_nxt = PH_CHAN;
          end else begin
            running_nxt = 8'd0;
            if (data_byte == ST_SYSEX) begin
              phase_nxt = PH_SYSEX;
            end else if (data_byte == ST_META) begin
              phase_nxt = PH_MTYPE;
            end else if (data_byte == ST_SONG_POS) begin
              dl_nxt = 2'd2;
              phase_nxt = PH_SYS;
            end else if (data_byte == ST_SONG_SEL) begin
              dl_nxt = 2'd1;
              phase_nxt = PH_SYS;
            end else begin
              do_fin  = 1'b1;
              fin_cls = CLS_SYSTEM;
            end
          end
        end else if (running_nxt == 8'd0) begin
          do_fin  = 1'b1;
          fin_cls = CLS_ERROR;
        end else begin
          // running status: this byte is the first data byte
          cur_nxt = running_nxt;
          if (running_nxt[7:4] == HI_PROG || running_nxt[7:4] == HI_PRESS) begin
            dl_nxt  = 2'd0;
            do_chan = 1'b1;
          end else begin
            dl_nxt    = 2'd1;
            phase_nxt = PH_CHAN;
          end
        end
      end
      PH_CHAN: begin
        dl_nxt = dl_nxt - 2'd1;
        if (dl_nxt == 2'd0) do_chan = 1'b1;
      end
      PH_SYS: begin
        dl_nxt = dl_nxt - 2'd1;
        if (dl_nxt == 2'd0) begin
          do_fin  = 1'b1;
          fin_cls = CLS_SYSTEM;
        end
      end
      PH_SYSEX: begin
        if (data_byte == ST_SYSEX_END) begin
          do_fin  = 1'b1;
          fin_cls = CLS_SYSEX;
        end
      end
      PH_MTYPE: begin
        meta_nxt  = data_byte;
        vlq_nxt   = 28'd0;
        phase_nxt = PH_MLEN;
      end
      PH_MLEN: begin
        vlq_nxt = vlq_sh7;
        if (!data_byte[7]) begin
          skip_nxt = vlq_sh7;
          vlq_nxt  = 28'd0;
          if (vlq_sh7 == 28'd0) do_meta = 1'b1;
          else phase_nxt = PH_MDATA;
        end
      end
      PH_MDATA: begin
        vlq_nxt  = {4'd0, vlq_nxt[15:0], data_byte};
        skip_nxt = skip_nxt - 28'd1;
        if (skip_nxt == 28'd0) begin
          do_meta   = 1'b1;
          meta_load = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (do_chan) begin
      do_fin = 1'b1;
      ev_ch  = cur_nxt[3:0];
      if (cur_nxt[7:4] == ST_NOTE_ON[7:4]) begin
        fin_cls = CLS_NOTE_ON;
        if (~&note_nxt) note_nxt = note_nxt + COUNT_BITS'(1);
        if (~&poly_nxt) poly_nxt = poly_nxt + 16'd1;
      end else if (cur_nxt[7:4] == ST_NOTE_OFF[7:4]) begin
        fin_cls = CLS_NOTE_OFF;
        if (|poly_nxt) poly_nxt = poly_nxt - 16'd1;
      end else begin
        fin_cls = CLS_CHAN;
      end
    end

    if (do_meta) begin
      do_fin = 1'b1;
      if (meta_nxt == META_EOT) begin
        ended_nxt = 1'b1;
        fin_cls   = CLS_END;
        to_done   = 1'b1;
      end else if (meta_nxt == META_TEMPO) begin
        if (meta_load) tempo_nxt = vlq_nxt[23:0];
        fin_cls = CLS_TEMPO;
      end else begin
        fin_cls = CLS_META;
      end
    end

    if (do_fin) begin
      ev_end    = 1'b1;
      ev_cls    = fin_cls;
      vlq_nxt   = 28'd0;
      phase_nxt = to_done ? PH_DONE : PH_DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_DELTA;
      running_r <= 8'd0;
      cur_r     <= 8'd0;
      meta_r    <= 8'd0;
      vlq_r     <= 28'd0;
      skip_r    <= 28'd0;
      dl_r      <= 2'd0;
      tick_r    <= '0;
      note_r    <= '0;
      poly_r    <= 16'd0;
      tempo_r   <= TEMPO_RESET;
      ended_r   <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      running_r <= running_nxt;
      cur_r     <= cur_nxt;
      meta_r    <= meta_nxt;
      vlq_r     <= vlq_nxt;
      skip_r    <= skip_nxt;
      dl_r      <= dl_nxt;
      tick_r    <= tick_nxt;
      note_r    <= note_nxt;
      poly_r    <= poly_nxt;
      tempo_r   <= tempo_nxt;
      ended_r   <= ended_nxt;
    end
  end

  // saturate the wide counters onto the 32-bit result fields
  logic [31:0] tick_out;
  logic [31:0] note_out;

  generate
    if (TICK_BITS > 32) begin : g_tick_wide
      assign tick_out = (|tick_nxt[TICK_BITS-1:32]) ? '1 : tick_nxt[31:0];
    end else if (TICK_BITS == 32) begin : g_tick_eq
      assign tick_out = tick_nxt;
    end else begin : g_tick_narrow
      assign tick_out = {{(32-TICK_BITS){1'b0}}, tick_nxt};
    end
    if (COUNT_BITS > 32) begin : g_note_wide
      assign note_out = (|note_nxt[COUNT_BITS-1:32]) ? '1 : note_nxt[31:0];
    end else if (COUNT_BITS == 32) begin : g_note_eq
      assign note_out = note_nxt;
    end else begin : g_note_narrow
      assign note_out = {{(32-COUNT_BITS){1'b0}}, note_nxt};
    end
  endgenerate

  always_comb begin
    res.event_end   = ev_end;
    res.event_class = ev_cls;
    res.channel     = ev_ch;
    res.tick_time   = tick_out;
    res.note_total  = note_out;
    res.voices      = poly_nxt;
    res.tempo_us    = tempo_nxt;
    res.track_done  = ended_nxt;
  end

  // the end-of-track event always lands in the done phase
  a_end_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev_end && ev_cls == CLS_END |=> phase_r == PH_DONE && ended_r)
    else $error("end of track did not park the parser");

  // once done, bytes without a track start leave the parse untouched
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_DONE && !track_start |-> !ev_end)
    else $error("event reported after end of track");

  // a completed event always clears the length accumulator
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev_end |=> vlq_r == 28'd0)
    else $error("accumulator left dirty after event");

endmodule

@@ src/midi_track_event_parser.sv @@
`timescale 1ns / 1ps
// top level of the midi track event parser: input register, decode, result register
// depends on mtep_pkg and mtep_parse
//
// usage
//   input channel: one track byte per request (in_data_byte), with in_track_start
//   high on the first byte of a track; that clears the tick time, running status
//   and the done flag before the byte is parsed. note count, polyphony and tempo
//   carry over between tracks.
//   result channel: exactly one request per input byte, in order. out_event_end
//   marks the byte that completes an event; class and channel are zero otherwise.
//   tick time, note total, voices, tempo and track done always show the state
//   after that byte.
//   out_valid rises once an accepted byte has passed the input register and then
//   been decoded into the result register. throughput: one byte per cycle while
//   out_ready stays high, set by the single pass of decode logic between the two
//   registers.
//   stall: while out_ready is low the result register holds; the input register
//   still takes one more byte, after which in_ready drops until the result moves.
//   reset: synchronous, active low; both registers empty, tick and counters zero,
//   tempo 500000 us per quarter note, parser waiting for a delta time.
module midi_track_event_parser import mtep_pkg::*; #(
  parameter int TICK_BITS  = MTEP_TICK_BITS,
  parameter int COUNT_BITS = MTEP_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_event_end,
  output logic [3:0]  out_event_class,
  output logic [3:0]  out_channel,
  output logic [31:0] out_tick_time,
  output logic [31:0] out_note_total,
  output logic [15:0] out_voices,
  output logic [23:0] out_tempo_us,
  output logic        out_track_done
);

  // input register
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       start_r;

  // result register
  logic         out_vld_r;
  mtep_result_t res_r;
  mtep_result_t res_nxt;

  // the byte in the input register is decoded when the result slot is free or leaving
  logic advance;
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_data_byte;
      start_r <= in_track_start;
    end
  end

  mtep_parse #(
    .TICK_BITS  (TICK_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .data_byte   (byte_r),
    .track_start (start_r),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_event_end   = res_r.event_end;
  assign out_event_class = res_r.event_class;
  assign out_channel     = res_r.channel;
  assign out_tick_time   = res_r.tick_time;
  assign out_note_total  = res_r.note_total;
  assign out_voices      = res_r.voices;
  assign out_tempo_us    = res_r.tempo_us;
  assign out_track_done  = res_r.track_done;

  // input side only backs up when both registers are full and the receiver stalls
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && out_vld_r && !out_ready)
    else $error("input stalled without a full pipe");

  // class and channel are quiet on bytes that complete nothing
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_event_end |-> out_event_class == CLS_NOTE_ON && out_channel == 4'd0)
    else $error("class or channel set without an event");

  // the note total never goes backwards from one result to the next
  a_notes_grow: assert property (@(posedge clk) disable iff (!rst_n)
    advance && out_vld_r |=> out_note_total >= $past(out_note_total))
    else $error("note total decreased");

  // an end-of-track event always reports the track as done
  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_event_end && out_event_class == CLS_END |-> out_track_done)
    else $error("end of track without done flag");

endmodule
